FILE: hdl/lkv_pkg.sv
package lkv_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAPACITY_W = 7;

   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 7'd64;
   localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // broadcast from the controller to every cell of the chain
   typedef struct packed {
      logic compare;   // latch the key match of this request
      logic update;    // apply the shift computed from the latched matches
      logic hit_any;   // some cell matched
      logic evict;     // a miss drops the least recent entry
   } cell_ctl_type;

endpackage

FILE: hdl/lkv_cell.sv
module lkv_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  lkv_pkg::cell_ctl_type            ctl,
   input  logic [lkv_pkg::KEY_W-1:0]        lookup_key,
   input  logic                             left_valid,
   input  logic [lkv_pkg::KEY_W-1:0]        left_key,
   input  logic [lkv_pkg::VAL_W-1:0]        left_value,
   input  logic                             below_match,
   input  logic [lkv_pkg::VAL_W-1:0]        below_value,
   output logic                             valid,
   output logic [lkv_pkg::KEY_W-1:0]        key,
   output logic [lkv_pkg::VAL_W-1:0]        value,
   output logic                             match,
   output logic                             up_match,
   output logic [lkv_pkg::VAL_W-1:0]        up_value
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [lkv_pkg::KEY_W-1:0]   key_ff;
   logic [lkv_pkg::VAL_W-1:0]   value_ff;
   logic                        match_ff;
   logic                        shift;

   // gather the hit flag and hit value from this cell and the ones behind it
   assign up_match = match_ff | below_match;
   assign up_value = (match_ff ? value_ff : '0) | below_value;

   // pick which cells move back one place in the recency order
   always_comb begin
      if (ctl.hit_any) begin
         shift = up_match;
      end else if (ctl.evict) begin
         shift = valid_ff;
      end else begin
         shift = valid_ff | left_valid;
      end
      valid_in = (ctl.update && shift) ? left_valid : valid_ff;
   end

   // hold valid and match flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.compare) begin
            match_ff <= valid_ff && (key_ff == lookup_key);
         end
      end
   end

   // take the neighbor's entry on a shift
   always_ff @(posedge clock) begin
      if (ctl.update && shift) begin
         key_ff   <= left_key;
         value_ff <= left_value;
      end
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign value = value_ff;
   assign match = match_ff;

endmodule

FILE: hdl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement,
// built as a row of ENTRIES cells kept in recency order (cell 0 is the most
// recent entry, valid cells form a prefix). A request is accepted in the idle
// state, in the compare state all cells compare the key in parallel and
// register the match, and in the update state the chosen cells shift one
// place back and the hit or new entry lands in cell 0. A get whose result
// finds the output register still full waits in the update state until
// that beat is taken; a put never waits. A get returns found and the stored
// value, or found clear and all ones on a miss; a put returns nothing. The
// capacity register limits occupancy (0 acts as 1, values above ENTRIES act
// as ENTRIES) and is to be written only while the cache is idle, which the
// block does not enforce. The store is empty after reset with no clearing pass.
module lru_key_value_cache #(
   parameter int ENTRIES = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [lkv_pkg::CAPACITY_W-1:0]          csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_command,
   input  logic signed [lkv_pkg::KEY_W-1:0]        req_key,
   input  logic signed [lkv_pkg::VAL_W-1:0]        req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_found,
   output logic signed [lkv_pkg::VAL_W-1:0]        rsp_read_value
);

   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CW = (OCC_W > lkv_pkg::CAPACITY_W) ? OCC_W : lkv_pkg::CAPACITY_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

   state_type                        state_ff;
   state_type                        state_in;
   logic [lkv_pkg::CAPACITY_W-1:0]   csr_capacity_ff;
   logic [OCC_W-1:0]                 occ_ff;
   logic [OCC_W-1:0]                 occ_in;
   logic                             evict_ff;
   logic                             cmd_ff;
   logic [lkv_pkg::KEY_W-1:0]        key_ff;
   logic [lkv_pkg::VAL_W-1:0]        value_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic                             rsp_found_ff;
   logic [lkv_pkg::VAL_W-1:0]        rsp_value_ff;

   logic                             req_accept;
   logic                             rsp_free;
   logic                             upd_go;
   logic                             hit_any;
   logic [CW-1:0]                    cap_wide;
   logic [CW-1:0]                    cap_eff;
   lkv_pkg::cell_ctl_type            ctl;

   logic                             chain_valid [ENTRIES+1];
   logic [lkv_pkg::KEY_W-1:0]        chain_key   [ENTRIES+1];
   logic [lkv_pkg::VAL_W-1:0]        chain_value [ENTRIES+1];
   logic                             chain_match [ENTRIES+1];
   logic [lkv_pkg::VAL_W-1:0]        chain_hit   [ENTRIES+1];
   logic [ENTRIES-1:0]               valid_vec;
   logic [ENTRIES-1:0]               match_vec;

   // handshake
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // clamp the capacity register into 1..ENTRIES
   always_comb begin
      cap_wide = CW'(csr_capacity_ff);
      if (cap_wide == '0) begin
         cap_eff = CW'(1);
      end else if (cap_wide > CW'(ENTRIES)) begin
         cap_eff = CW'(ENTRIES);
      end else begin
         cap_eff = cap_wide;
      end
   end

   // hold the capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_capacity_ff <= lkv_pkg::CAPACITY_RESET;
      end else if (csr_write_enable) begin
         csr_capacity_ff <= csr_write_data;
      end
   end

   // sequence one request: accept, compare, update
   always_comb begin
      hit_any      = chain_match[0];
      upd_go       = (state_ff == ST_UPD) && ((cmd_ff == lkv_pkg::CMD_PUT) || rsp_free);
      state_in     = state_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_go) begin
               state_in = ST_IDLE;
               if (cmd_ff == lkv_pkg::CMD_GET) begin
                  rsp_valid_in = 1'b1;
               end else if (!hit_any && !evict_ff) begin
                  occ_in = occ_ff + OCC_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ctl.compare = (state_ff == ST_CMP);
      ctl.update  = upd_go && (hit_any || (cmd_ff == lkv_pkg::CMD_PUT));
      ctl.hit_any = hit_any;
      ctl.evict   = evict_ff;
   end

   // hold state, occupancy, the request and the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CMP) begin
            evict_ff <= (CW'(occ_ff) >= cap_eff);
         end
      end
      if (req_accept) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (upd_go && (cmd_ff == lkv_pkg::CMD_GET)) begin
         rsp_found_ff <= hit_any;
         rsp_value_ff <= hit_any ? chain_hit[0] : lkv_pkg::MISS_VALUE;
      end
   end

   // feed the head of the chain: request key, and the hit value on a get
   assign chain_valid[0] = 1'b1;
   assign chain_key[0]   = key_ff;
   assign chain_value[0] = (cmd_ff == lkv_pkg::CMD_GET) ? chain_hit[0] : value_ff;
   assign chain_match[ENTRIES] = 1'b0;
   assign chain_hit[ENTRIES]   = '0;

   // build the row of cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkv_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .lookup_key  (key_ff),
         .left_valid  (chain_valid[i]),
         .left_key    (chain_key[i]),
         .left_value  (chain_value[i]),
         .below_match (chain_match[i+1]),
         .below_value (chain_hit[i+1]),
         .valid       (chain_valid[i+1]),
         .key         (chain_key[i+1]),
         .value       (chain_value[i+1]),
         .match       (match_vec[i]),
         .up_match    (chain_match[i]),
         .up_value    (chain_hit[i])
      );
      assign valid_vec[i] = chain_valid[i+1];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   // occupancy tracks the valid cells, which always form a prefix
   a_occ_matches: assert property (@(posedge clock) disable iff (reset)
      ($countones(valid_vec) == int'(occ_ff)) && (((valid_vec >> 1) & ~valid_vec) == '0))
      else $error("valid cells disagree with occupancy or are not a prefix");

   // a key sits in at most one cell
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> $onehot0(match_vec))
      else $error("key matched in more than one cell");

   // a result beat appears only out of the update cycle of a get
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upd_go && (cmd_ff == lkv_pkg::CMD_GET)))
      else $error("result beat without a finished get");

   // occupancy never passes the number of cells
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) <= ENTRIES)
      else $error("occupancy above cell count");

endmodule
